/* rtl/trs_pkg.sv */
package trs_pkg;

  // Default fixed-point formats.
  localparam int TRS_FRAC_BITS  = 16;
  localparam int TRS_ANGLE_BITS = 16;

  // CORDIC setup: 30 steps, start vector at the inverse gain in Q2.30.
  localparam int CORDIC_STEPS = 30;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // Angle of each CORDIC step in units of 2^-32 turn, truncated.
  localparam logic [29:0] ATAN_TURN [CORDIC_STEPS] = '{
    30'h20000000, 30'h12E4051D, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
    30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2E, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2F9, 30'h0000517C, 30'h000028BE, 30'h0000145F,
    30'h00000A2F, 30'h00000517, 30'h0000028B, 30'h00000145, 30'h000000A2, 30'h00000051,
    30'h00000028, 30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000002, 30'h00000001
  };

  // Axis count and index of each axis.
  localparam int AXES   = 3;
  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;

  // Classified word: 2D mode applied, angles turned into 32-bit phases.
  typedef struct packed {
    logic signed [31:0]   px;
    logic signed [31:0]   py;
    logic signed [31:0]   pz;
    logic signed [31:0]   kx;
    logic signed [31:0]   ky;
    logic signed [31:0]   kz;
    logic [AXES-1:0][31:0] phase;
  } item_t;

endpackage

/* rtl/trs_in_if.sv */
interface trs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] scale_x;
  logic signed [31:0] scale_y;
  logic signed [31:0] scale_z;
  logic [15:0]        angle_x;
  logic [15:0]        angle_y;
  logic [15:0]        angle_z;

  modport source (output valid, pos_x, pos_y, pos_z, scale_x, scale_y, scale_z,
                  angle_x, angle_y, angle_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, scale_x, scale_y, scale_z,
                angle_x, angle_y, angle_z, output ready);
endinterface

/* rtl/trs_out_if.sv */
interface trs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] elem_0;
  logic signed [31:0] elem_1;
  logic signed [31:0] elem_2;
  logic signed [31:0] elem_4;
  logic signed [31:0] elem_5;
  logic signed [31:0] elem_6;
  logic signed [31:0] elem_8;
  logic signed [31:0] elem_9;
  logic signed [31:0] elem_10;
  logic signed [31:0] elem_12;
  logic signed [31:0] elem_13;
  logic signed [31:0] elem_14;

  modport source (output valid, elem_0, elem_1, elem_2, elem_4, elem_5, elem_6,
                  elem_8, elem_9, elem_10, elem_12, elem_13, elem_14, input ready);
  modport sink (input valid, elem_0, elem_1, elem_2, elem_4, elem_5, elem_6,
                elem_8, elem_9, elem_10, elem_12, elem_13, elem_14, output ready);
endinterface

/* rtl/trs_front.sv */
module trs_front #(
  parameter int FRAC_BITS  = trs_pkg::TRS_FRAC_BITS,
  parameter int ANGLE_BITS = trs_pkg::TRS_ANGLE_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  trs_in_if.sink          in_ch,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  output logic            f_valid,
  input  logic            f_ready,
  output trs_pkg::item_t  f_item
);

  localparam int PHASE_SHIFT = 32 - ANGLE_BITS;

  logic           two_d_r;
  logic           valid_r;
  trs_pkg::item_t item_r;
  trs_pkg::item_t item_nxt;

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      two_d_r <= 1'b0;
    end else if (cfg_we) begin
      two_d_r <= cfg_wdata;
    end
  end

  // Classify the word: apply 2D mode and scale each angle to a full 32-bit phase.
  always_comb begin
    item_nxt.px = in_ch.pos_x;
    item_nxt.py = in_ch.pos_y;
    item_nxt.pz = two_d_r ? 32'sd0 : in_ch.pos_z;
    item_nxt.kx = in_ch.scale_x;
    item_nxt.ky = in_ch.scale_y;
    item_nxt.kz = two_d_r ? (32'sd1 <<< FRAC_BITS) : in_ch.scale_z;
    item_nxt.phase[trs_pkg::AXIS_X] = two_d_r ? 32'd0 : (32'(in_ch.angle_x) << PHASE_SHIFT);
    item_nxt.phase[trs_pkg::AXIS_Y] = two_d_r ? 32'd0 : (32'(in_ch.angle_y) << PHASE_SHIFT);
    item_nxt.phase[trs_pkg::AXIS_Z] = 32'(in_ch.angle_z) << PHASE_SHIFT;
  end

  assign in_ch.ready = !valid_r || f_ready;

  // Holding register toward the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r <= item_nxt;
    end
  end

  assign f_valid = valid_r;
  assign f_item  = item_r;

endmodule

/* rtl/trs_queue.sv */
module trs_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  trs_pkg::item_t  push_item,
  output logic            pop_valid,
  input  logic            pop,
  output trs_pkg::item_t  pop_item
);

  localparam int PTR_W = $clog2(trs_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(trs_pkg::QUEUE_DEPTH + 1);

  trs_pkg::item_t   slot_r [trs_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             take;

  assign push_ready = count_r < CNT_W'(trs_pkg::QUEUE_DEPTH);
  assign push       = push_valid && push_ready;
  assign pop_valid  = count_r != '0;
  assign take       = pop && pop_valid;
  assign pop_item   = slot_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(trs_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (take) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(trs_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !take) begin
        count_r <= count_r + 1'b1;
      end else if (take && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(trs_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  // A lone push raises the count by one.
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    push && !take |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count missed a push");

  // A lone pop lowers the count by one.
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    take && !push |=> count_r == $past(count_r) - 1'b1)
    else $error("queue count missed a pop");

endmodule

/* rtl/trs_back.sv */
module trs_back #(
  parameter int FRAC_BITS = trs_pkg::TRS_FRAC_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_pop,
  input  trs_pkg::item_t  q_item,
  trs_out_if.source       out_ch
);

  localparam int STEPS = trs_pkg::CORDIC_STEPS;
  localparam int AX    = trs_pkg::AXES;
  localparam int XA    = trs_pkg::AXIS_X;
  localparam int YA    = trs_pkg::AXIS_Y;
  localparam int ZA    = trs_pkg::AXIS_Z;

  // Saturate a grown sum to 32-bit signed.
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh07FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -34'sh080000000) begin
      r = -32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Fixed-point product, rounded half up and saturated.
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [63:0] s;
    logic signed [31:0] r;
    p = (64'(a) * 64'(b)) + (64'sd1 <<< (FRAC_BITS - 1));
    s = p >>> FRAC_BITS;
    if (s > 64'sh7FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (s < -64'sh80000000) begin
      r = -32'sh80000000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  // Round a Q2.30 CORDIC value to FRAC_BITS and clamp to plus or minus one.
  function automatic logic signed [31:0] to_frac(input logic signed [34:0] v);
    logic signed [34:0] t;
    logic signed [34:0] one;
    logic signed [31:0] r;
    one = 35'sd1 <<< FRAC_BITS;
    t   = (v + (35'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    if (t > one) begin
      r = one[31:0];
    end else if (t < -one) begin
      r = -one[31:0];
    end else begin
      r = t[31:0];
    end
    return r;
  endfunction

  logic en;
  logic out_valid_r;

  // The whole back pipeline moves unless the output word is stalled.
  assign en    = !out_valid_r || out_ch.ready;
  assign q_pop = en;

  // CORDIC step registers, one row per step.
  logic signed [33:0] x_r [STEPS][AX];
  logic signed [33:0] y_r [STEPS][AX];
  logic signed [32:0] z_r [STEPS][AX];
  trs_pkg::item_t     it_r [STEPS];
  logic [STEPS-1:0]   cv_r;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic signed [33:0] xi [AX];
    logic signed [33:0] yi [AX];
    logic signed [32:0] zi [AX];
    trs_pkg::item_t     ii;
    logic               vi;

    if (k == 0) begin : g_first
      for (genvar a = 0; a < AX; a++) begin : g_ax
        assign xi[a] = trs_pkg::CORDIC_GAIN;
        assign yi[a] = '0;
        assign zi[a] = {3'b000, q_item.phase[a][29:0]};
      end
      assign ii = q_item;
      assign vi = q_valid;
    end else begin : g_next
      for (genvar a = 0; a < AX; a++) begin : g_ax
        assign xi[a] = x_r[k-1][a];
        assign yi[a] = y_r[k-1][a];
        assign zi[a] = z_r[k-1][a];
      end
      assign ii = it_r[k-1];
      assign vi = cv_r[k-1];
    end

    // One micro-rotation per axis toward zero residual angle.
    always_ff @(posedge clk) begin
      if (en) begin
        for (int a = 0; a < AX; a++) begin
          if (!zi[a][32]) begin
            x_r[k][a] <= xi[a] - (yi[a] >>> k);
            y_r[k][a] <= yi[a] + (xi[a] >>> k);
            z_r[k][a] <= zi[a] - 33'(trs_pkg::ATAN_TURN[k]);
          end else begin
            x_r[k][a] <= xi[a] + (yi[a] >>> k);
            y_r[k][a] <= yi[a] - (xi[a] >>> k);
            z_r[k][a] <= zi[a] + 33'(trs_pkg::ATAN_TURN[k]);
          end
        end
        it_r[k] <= ii;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[k] <= 1'b0;
      end else if (en) begin
        cv_r[k] <= vi;
      end
    end
  end

  // Quadrant rotation and rounding to sine and cosine.
  logic signed [31:0] cs_r [AX];
  logic signed [31:0] sn_r [AX];
  trs_pkg::item_t     itf_r;
  logic               fv_r;

  always_ff @(posedge clk) begin
    logic signed [34:0] xe;
    logic signed [34:0] ye;
    if (en) begin
      for (int a = 0; a < AX; a++) begin
        xe = 35'(x_r[STEPS-1][a]);
        ye = 35'(y_r[STEPS-1][a]);
        unique case (it_r[STEPS-1].phase[a][31:30])
          2'd0: begin
            cs_r[a] <= to_frac(xe);
            sn_r[a] <= to_frac(ye);
          end
          2'd1: begin
            cs_r[a] <= to_frac(-ye);
            sn_r[a] <= to_frac(xe);
          end
          2'd2: begin
            cs_r[a] <= to_frac(-xe);
            sn_r[a] <= to_frac(-ye);
          end
          default: begin
            cs_r[a] <= to_frac(ye);
            sn_r[a] <= to_frac(-xe);
          end
        endcase
      end
      itf_r <= it_r[STEPS-1];
    end
  end

  // First products of the rotation terms.
  logic signed [31:0] cycz_r, sxsy_r, cxsy_r, cxsz_r, cysz_r;
  logic signed [31:0] sxsz_r, cxcz_r, sxcz_r, sxcy_r, cxcy_r;
  logic signed [31:0] sny_r, cz_r, snz_r;
  trs_pkg::item_t     it1_r;
  logic               v1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cycz_r <= qmul(cs_r[YA], cs_r[ZA]);
      sxsy_r <= qmul(sn_r[XA], sn_r[YA]);
      cxsy_r <= qmul(cs_r[XA], sn_r[YA]);
      cxsz_r <= qmul(cs_r[XA], sn_r[ZA]);
      cysz_r <= qmul(cs_r[YA], sn_r[ZA]);
      sxsz_r <= qmul(sn_r[XA], sn_r[ZA]);
      cxcz_r <= qmul(cs_r[XA], cs_r[ZA]);
      sxcz_r <= qmul(sn_r[XA], cs_r[ZA]);
      sxcy_r <= qmul(sn_r[XA], cs_r[YA]);
      cxcy_r <= qmul(cs_r[XA], cs_r[YA]);
      sny_r  <= sn_r[YA];
      cz_r   <= cs_r[ZA];
      snz_r  <= sn_r[ZA];
      it1_r  <= itf_r;
    end
  end

  // Second products and the sums of the rotation matrix.
  logic signed [31:0] r_r [9];
  trs_pkg::item_t     it2_r;
  logic               v2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0] <= cycz_r;
      r_r[1] <= sat34(34'(qmul(sxsy_r, cz_r)) + 34'(cxsz_r));
      r_r[2] <= sat34(-34'(qmul(cxsy_r, cz_r)) + 34'(sxsz_r));
      r_r[3] <= sat34(-34'(cysz_r));
      r_r[4] <= sat34(-34'(qmul(sxsy_r, snz_r)) + 34'(cxcz_r));
      r_r[5] <= sat34(34'(qmul(cxsy_r, snz_r)) + 34'(sxcz_r));
      r_r[6] <= sny_r;
      r_r[7] <= sat34(-34'(sxcy_r));
      r_r[8] <= cxcy_r;
      it2_r  <= it1_r;
    end
  end

  // Column scaling into the output register.
  logic signed [31:0] e_r [12];

  always_ff @(posedge clk) begin
    if (en) begin
      e_r[0]  <= qmul(r_r[0], it2_r.kx);
      e_r[1]  <= qmul(r_r[1], it2_r.kx);
      e_r[2]  <= qmul(r_r[2], it2_r.kx);
      e_r[3]  <= qmul(r_r[3], it2_r.ky);
      e_r[4]  <= qmul(r_r[4], it2_r.ky);
      e_r[5]  <= qmul(r_r[5], it2_r.ky);
      e_r[6]  <= qmul(r_r[6], it2_r.kz);
      e_r[7]  <= qmul(r_r[7], it2_r.kz);
      e_r[8]  <= qmul(r_r[8], it2_r.kz);
      e_r[9]  <= it2_r.px;
      e_r[10] <= it2_r.py;
      e_r[11] <= it2_r.pz;
    end
  end

  // Valid bits of the tail stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      fv_r        <= cv_r[STEPS-1];
      v1_r        <= fv_r;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.elem_0  = e_r[0];
  assign out_ch.elem_1  = e_r[1];
  assign out_ch.elem_2  = e_r[2];
  assign out_ch.elem_4  = e_r[3];
  assign out_ch.elem_5  = e_r[4];
  assign out_ch.elem_6  = e_r[5];
  assign out_ch.elem_8  = e_r[6];
  assign out_ch.elem_9  = e_r[7];
  assign out_ch.elem_10 = e_r[8];
  assign out_ch.elem_12 = e_r[9];
  assign out_ch.elem_13 = e_r[10];
  assign out_ch.elem_14 = e_r[11];

  // A word taken from the queue enters the first CORDIC step.
  a_pop_enters: assert property (@(posedge clk) disable iff (!rst_n)
    en && q_valid |=> cv_r[0])
    else $error("popped word lost at CORDIC entry");

  // While stalled, the tail of the pipeline holds its valid bits.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> fv_r == $past(fv_r) && v2_r == $past(v2_r))
    else $error("pipeline moved during stall");

  // The Z-axis cosine never exceeds one in magnitude.
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (cz_r <= (32'sd1 <<< FRAC_BITS)) && (cz_r >= -(32'sd1 <<< FRAC_BITS)))
    else $error("cosine out of range");

endmodule

/* rtl/euler_trs_matrix.sv */
// Euler X-Y-Z rotation, scale and translation matrix: each input word (position, scale and
// three angles as fractions of a turn) yields one word with the twelve non-constant elements
// of a column-major 4x4 world matrix in signed fixed point with saturation. The block takes
// one word per cycle unless a stalled output has filled the queue. Each word passes the
// classifying front register, the four-word queue, 30 pipelined CORDIC sine/cosine stages
// (one step per stage, three axes side by side), a quadrant rounding stage and three
// multiplier stages, the last being the output register. A stalled output halts the back
// pipeline while the queue keeps taking words until it fills. The user must write the
// two_d_mode register through cfg_we/cfg_wdata only while the block is idle (not enforced).
module euler_trs_matrix #(
  parameter int FRAC_BITS  = trs_pkg::TRS_FRAC_BITS,
  parameter int ANGLE_BITS = trs_pkg::TRS_ANGLE_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  trs_in_if.sink    in_ch,
  trs_out_if.source out_ch,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic           f_valid;
  logic           f_ready;
  trs_pkg::item_t f_item;
  logic           q_valid;
  logic           q_pop;
  trs_pkg::item_t q_item;

  // Front: mode register and classification.
  trs_front #(
    .FRAC_BITS  (FRAC_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .f_valid   (f_valid),
    .f_ready   (f_ready),
    .f_item    (f_item)
  );

  // Queue decoupling the two parts.
  trs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  // Back: CORDIC and matrix arithmetic.
  trs_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_item  (q_item),
    .out_ch  (out_ch)
  );

endmodule
